>>> src/lei_pkg.sv
// Shared constants, types and fixed-point helpers for the Lorenz Euler integrator.
package lei_pkg;

  // Fixed-point format
  localparam int FRAC_BITS   = 20;
  localparam int VALUE_WIDTH = 32;
  localparam int TIME_WIDTH  = 48;
  localparam int COEF_WIDTH  = 32;
  localparam int LIMIT_WIDTH = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Multiplier operand and product widths (operands carry one guard bit for differences)
  localparam int OPW = ((VALUE_WIDTH > COEF_WIDTH) ? VALUE_WIDTH : COEF_WIDTH) + 1;
  localparam int PW  = 2 * OPW;

  // Reset values of the coefficient registers
  localparam logic signed [COEF_WIDTH-1:0] SIGMA_RST = COEF_WIDTH'(10485760);
  localparam logic signed [COEF_WIDTH-1:0] RHO_RST   = COEF_WIDTH'(29360128);
  localparam logic signed [COEF_WIDTH-1:0] BETA_RST  = COEF_WIDTH'(2796203);
  localparam logic signed [COEF_WIDTH-1:0] STEP_RST  = COEF_WIDTH'(10486);
  localparam logic [LIMIT_WIDTH-1:0]       LIMIT_RST = LIMIT_WIDTH'(1000);

  // Saturation bounds
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [TIME_WIDTH-1:0]  TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
  localparam logic signed [TIME_WIDTH-1:0]  TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA = 3'd0,
    REG_RHO   = 3'd1,
    REG_BETA  = 3'd2,
    REG_STEP  = 3'd3,
    REG_LIMIT = 3'd4
  } cfg_idx_t;

  // Control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Sequencer phases: one multiply issued per phase, product of the prior phase retired
  typedef enum logic [2:0] {
    PH_SIG_YX = 3'd0,
    PH_X_RZ   = 3'd1,
    PH_X_Y    = 3'd2,
    PH_BETA_Z = 3'd3,
    PH_H_DX   = 3'd4,
    PH_H_DY   = 3'd5,
    PH_H_DZ   = 3'd6,
    PH_LAST   = 3'd7
  } phase_t;

  // Saturated value with its clip flag
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] val;
    logic                          sat;
  } fx_res_t;

  // Floor-shift a full product by FRAC_BITS and clip to VALUE_WIDTH
  function automatic fx_res_t fx_scale(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    logic [PW-VALUE_WIDTH:0] top;
    fx_res_t r;
    q   = p >>> FRAC_BITS;
    top = q[PW-1:VALUE_WIDTH-1];
    if ((&top) || !(|top)) begin
      r.val = q[VALUE_WIDTH-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = q[PW-1] ? VAL_MIN : VAL_MAX;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // Clip a sum one bit wider than VALUE_WIDTH back to VALUE_WIDTH
  function automatic fx_res_t fx_clip(input logic signed [VALUE_WIDTH:0] s);
    fx_res_t r;
    if (s[VALUE_WIDTH] == s[VALUE_WIDTH-1]) begin
      r.val = s[VALUE_WIDTH-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> src/lorenz_euler_integrator_top.sv
// Lorenz forward-Euler integrator: control sequencer, shared multiplier and state.
// A load or a step past the limit goes from the input transfer through the emit state
//   to the result register; an Euler step first runs the 8 sequencer phases.
// Items are taken one at a time: a new item is accepted only in idle, after the last
//   result is emitted; the single 33x33 multiplier forms the seven products of a step in turn.
//   A result held by the receiver stalls the emit state and so delays the next input transfer.
// Reset (rst, synchronous, active high) restores the coefficient defaults and zeroes
//   the point, time and step count; no output is pending after reset.
module lorenz_euler_integrator_top (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lei_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lei_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input items
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   mode,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_x,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_y,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_z,
  input  logic signed [lei_pkg::TIME_WIDTH-1:0]  start_time,
  // result items
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_x,
  output logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_y,
  output logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_z,
  output logic signed [lei_pkg::TIME_WIDTH-1:0]  cur_time,
  output logic [lei_pkg::LIMIT_WIDTH-1:0]        steps_done,
  output logic                                   limit_reached,
  output logic                                   saturated
);

  // Configuration registers
  logic signed [lei_pkg::COEF_WIDTH-1:0] sigma_coeff;
  logic signed [lei_pkg::COEF_WIDTH-1:0] rho_coeff;
  logic signed [lei_pkg::COEF_WIDTH-1:0] beta_coeff;
  logic signed [lei_pkg::COEF_WIDTH-1:0] step_size;
  logic [lei_pkg::LIMIT_WIDTH-1:0]       step_limit;

  // Integrator state
  logic signed [lei_pkg::VALUE_WIDTH-1:0] pos_x, pos_y, pos_z;
  logic signed [lei_pkg::TIME_WIDTH-1:0]  time_acc;
  logic [lei_pkg::LIMIT_WIDTH-1:0]        step_counter;

  // Sequencer
  lei_pkg::state_t state, state_next;
  lei_pkg::phase_t phase;
  logic            lim_flag;
  logic            sat_acc;

  // Datapath temporaries
  logic signed [lei_pkg::OPW-1:0]         op_a, op_b;
  logic signed [lei_pkg::PW-1:0]          prod;
  logic signed [lei_pkg::OPW-1:0]         dx, dy, dz;
  logic signed [lei_pkg::VALUE_WIDTH-1:0] xy_term;
  lei_pkg::fx_res_t                       scaled;
  lei_pkg::fx_res_t                       coord;
  logic signed [lei_pkg::VALUE_WIDTH-1:0] coord_base;
  logic signed [lei_pkg::TIME_WIDTH:0]    time_sum;
  logic signed [lei_pkg::TIME_WIDTH-1:0]  time_new;
  logic                                   time_sat;

  logic in_xfer, slot_free, at_limit;

  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign at_limit  = (step_counter >= step_limit);

  // Handshake outputs
  always_comb begin
    cfg_ready = 1'b1;
    in_ready  = (state == lei_pkg::ST_IDLE);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lei_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (mode == lei_pkg::MODE_LOAD || at_limit) state_next = lei_pkg::ST_EMIT;
          else state_next = lei_pkg::ST_CALC;
        end
      end
      lei_pkg::ST_CALC: begin
        if (phase == lei_pkg::PH_LAST) state_next = lei_pkg::ST_EMIT;
      end
      lei_pkg::ST_EMIT: begin
        if (slot_free) state_next = lei_pkg::ST_IDLE;
      end
      default: state_next = lei_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operand select per phase
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (phase)
      lei_pkg::PH_SIG_YX: begin
        op_a = lei_pkg::OPW'(sigma_coeff);
        op_b = lei_pkg::OPW'(pos_y) - lei_pkg::OPW'(pos_x);
      end
      lei_pkg::PH_X_RZ: begin
        op_a = lei_pkg::OPW'(pos_x);
        op_b = lei_pkg::OPW'(rho_coeff) - lei_pkg::OPW'(pos_z);
      end
      lei_pkg::PH_X_Y: begin
        op_a = lei_pkg::OPW'(pos_x);
        op_b = lei_pkg::OPW'(pos_y);
      end
      lei_pkg::PH_BETA_Z: begin
        op_a = lei_pkg::OPW'(beta_coeff);
        op_b = lei_pkg::OPW'(pos_z);
      end
      lei_pkg::PH_H_DX: begin
        op_a = lei_pkg::OPW'(step_size);
        op_b = dx;
      end
      lei_pkg::PH_H_DY: begin
        op_a = lei_pkg::OPW'(step_size);
        op_b = dy;
      end
      lei_pkg::PH_H_DZ: begin
        op_a = lei_pkg::OPW'(step_size);
        op_b = dz;
      end
      lei_pkg::PH_LAST: begin
        op_a = '0;
        op_b = '0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Shared scale/clip of the registered product, coordinate add and time add
  always_comb begin
    scaled = lei_pkg::fx_scale(prod);
    // h*dx retires in PH_H_DY, h*dy in PH_H_DZ, h*dz in PH_LAST
    unique case (phase)
      lei_pkg::PH_H_DZ: coord_base = pos_y;
      lei_pkg::PH_LAST: coord_base = pos_z;
      default:          coord_base = pos_x;
    endcase
    coord    = lei_pkg::fx_clip((lei_pkg::VALUE_WIDTH + 1)'(coord_base)
                                + (lei_pkg::VALUE_WIDTH + 1)'(scaled.val));
    time_sum = (lei_pkg::TIME_WIDTH + 1)'(time_acc) + (lei_pkg::TIME_WIDTH + 1)'(step_size);
    if (time_sum[lei_pkg::TIME_WIDTH] == time_sum[lei_pkg::TIME_WIDTH-1]) begin
      time_new = time_sum[lei_pkg::TIME_WIDTH-1:0];
      time_sat = 1'b0;
    end else begin
      time_new = time_sum[lei_pkg::TIME_WIDTH] ? lei_pkg::TIME_MIN : lei_pkg::TIME_MAX;
      time_sat = 1'b1;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lei_pkg::ST_IDLE;
      phase       <= lei_pkg::PH_SIG_YX;
      out_valid   <= 1'b0;
      sigma_coeff <= lei_pkg::SIGMA_RST;
      rho_coeff   <= lei_pkg::RHO_RST;
      beta_coeff  <= lei_pkg::BETA_RST;
      step_size   <= lei_pkg::STEP_RST;
      step_limit  <= lei_pkg::LIMIT_RST;
    end else begin
      state <= state_next;
      if (state == lei_pkg::ST_CALC) phase <= lei_pkg::phase_t'(phase + 3'd1);
      else phase <= lei_pkg::PH_SIG_YX;
      if (state == lei_pkg::ST_EMIT && slot_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lei_pkg::REG_SIGMA: sigma_coeff <= cfg_data[lei_pkg::COEF_WIDTH-1:0];
          lei_pkg::REG_RHO:   rho_coeff   <= cfg_data[lei_pkg::COEF_WIDTH-1:0];
          lei_pkg::REG_BETA:  beta_coeff  <= cfg_data[lei_pkg::COEF_WIDTH-1:0];
          lei_pkg::REG_STEP:  step_size   <= cfg_data[lei_pkg::COEF_WIDTH-1:0];
          lei_pkg::REG_LIMIT: step_limit  <= cfg_data[lei_pkg::LIMIT_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  // Integrator state: load, per-phase retire of products, commit of time and count
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
      time_acc     <= '0;
      step_counter <= '0;
      lim_flag     <= 1'b0;
      sat_acc      <= 1'b0;
    end else begin
      if (in_xfer) begin
        sat_acc  <= 1'b0;
        lim_flag <= (mode == lei_pkg::MODE_STEP) && at_limit;
        if (mode == lei_pkg::MODE_LOAD) begin
          pos_x        <= init_x;
          pos_y        <= init_y;
          pos_z        <= init_z;
          time_acc     <= start_time;
          step_counter <= '0;
        end
      end else if (state == lei_pkg::ST_CALC && phase != lei_pkg::PH_SIG_YX) begin
        // coordinate updates follow their h*d products
        unique case (phase)
          lei_pkg::PH_H_DY: begin
            pos_x   <= coord.val;
            sat_acc <= sat_acc | scaled.sat | coord.sat;
          end
          lei_pkg::PH_H_DZ: begin
            pos_y   <= coord.val;
            sat_acc <= sat_acc | scaled.sat | coord.sat;
          end
          lei_pkg::PH_LAST: begin
            pos_z        <= coord.val;
            time_acc     <= time_new;
            step_counter <= step_counter + 1'b1;
            sat_acc      <= sat_acc | scaled.sat | coord.sat | time_sat;
          end
          default: sat_acc <= sat_acc | scaled.sat;
        endcase
      end
    end
  end

  // Product register and derivative temporaries
  always_ff @(posedge clk) begin
    if (state == lei_pkg::ST_CALC) begin
      prod <= op_a * op_b;
      unique case (phase)
        lei_pkg::PH_X_RZ:   dx      <= lei_pkg::OPW'(scaled.val);
        lei_pkg::PH_X_Y:    dy      <= lei_pkg::OPW'(scaled.val) - lei_pkg::OPW'(pos_y);
        lei_pkg::PH_BETA_Z: xy_term <= scaled.val;
        lei_pkg::PH_H_DX:   dz      <= lei_pkg::OPW'(xy_term) - lei_pkg::OPW'(scaled.val);
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == lei_pkg::ST_EMIT && slot_free) begin
      cur_x         <= pos_x;
      cur_y         <= pos_y;
      cur_z         <= pos_z;
      cur_time      <= time_acc;
      steps_done    <= step_counter;
      limit_reached <= lim_flag;
      saturated     <= sat_acc;
    end
  end

  // A load always goes straight to the result stage
  a_load_emits: assert property (@(posedge clk) disable iff (rst)
    in_xfer && mode == lei_pkg::MODE_LOAD |=> state == lei_pkg::ST_EMIT)
    else $error("load did not go to emit");

  // The last phase of a step ends the calculation
  a_calc_ends: assert property (@(posedge clk) disable iff (rst)
    state == lei_pkg::ST_CALC && phase == lei_pkg::PH_LAST |=> state == lei_pkg::ST_EMIT)
    else $error("calculation did not end after last phase");

  // The sequencer starts each step from the first phase
  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    state != lei_pkg::ST_CALC |-> phase == lei_pkg::PH_SIG_YX)
    else $error("phase counter not cleared outside calculation");

  // An ignored step never reports clipping
  a_lim_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && limit_reached |-> !saturated)
    else $error("limit and saturation reported together");

  // A completed step advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == lei_pkg::ST_CALC && phase == lei_pkg::PH_LAST
      |=> step_counter == $past(step_counter) + 1'b1)
    else $error("step count did not advance");

endmodule

>>> test/lorenz_step_checker.sv
// Checker for the Lorenz Euler integrator: tracks config, predicts each result, compares.
`timescale 1ns / 100ps

module lorenz_step_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [lei_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lei_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   mode,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_x,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_y,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_z,
  input  logic signed [lei_pkg::TIME_WIDTH-1:0]  start_time,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_x,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_y,
  input  logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_z,
  input  logic signed [lei_pkg::TIME_WIDTH-1:0]  cur_time,
  input  logic [lei_pkg::LIMIT_WIDTH-1:0]        steps_done,
  input  logic                                   limit_reached,
  input  logic                                   saturated,
  output int                                     errors,
  output int                                     pending
);

  localparam longint VAL_HI  = longint'(lei_pkg::VAL_MAX);
  localparam longint VAL_LO  = longint'(lei_pkg::VAL_MIN);
  localparam longint TIME_HI = longint'(lei_pkg::TIME_MAX);
  localparam longint TIME_LO = longint'(lei_pkg::TIME_MIN);

  // One result as the block should report it
  typedef struct {
    logic signed [lei_pkg::VALUE_WIDTH-1:0] x;
    logic signed [lei_pkg::VALUE_WIDTH-1:0] y;
    logic signed [lei_pkg::VALUE_WIDTH-1:0] z;
    logic signed [lei_pkg::TIME_WIDTH-1:0]  t;
    logic [lei_pkg::LIMIT_WIDTH-1:0]        n;
    logic                                   lim;
    logic                                   sat;
  } lorenz_sample_t;

  // Shadow of the coefficient registers
  logic signed [lei_pkg::COEF_WIDTH-1:0] sigma, rho, beta, h;
  logic [lei_pkg::LIMIT_WIDTH-1:0]       step_cap;

  // Shadow of the integrator state
  logic signed [lei_pkg::VALUE_WIDTH-1:0] px, py, pz;
  logic signed [lei_pkg::TIME_WIDTH-1:0]  pt;
  logic [lei_pkg::LIMIT_WIDTH-1:0]        nsteps;

  lorenz_sample_t expected_points[$];
  lorenz_sample_t want;

  // floor(a*b / 2^FRAC_BITS), clipped to the value range
  function automatic longint fx_product(input longint a, input longint b, inout bit clipped);
    logic signed [127:0] wa, wb, wide;
    wa = a;
    wb = b;
    wide = (wa * wb) >>> lei_pkg::FRAC_BITS;
    if (wide > VAL_HI) begin
      clipped = 1'b1;
      return VAL_HI;
    end
    if (wide < VAL_LO) begin
      clipped = 1'b1;
      return VAL_LO;
    end
    return longint'(wide);
  endfunction

  function automatic longint clip_to(input longint v, input longint lo, input longint hi,
                                     inout bit clipped);
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Advance the shadow state by one input item and return the result it causes
  function automatic lorenz_sample_t apply_item(
      input logic m,
      input logic signed [lei_pkg::VALUE_WIDTH-1:0] ix,
      input logic signed [lei_pkg::VALUE_WIDTH-1:0] iy,
      input logic signed [lei_pkg::VALUE_WIDTH-1:0] iz,
      input logic signed [lei_pkg::TIME_WIDTH-1:0] it);
    lorenz_sample_t r;
    bit clipped;
    longint x, y, z, dx, dy, dz;
    clipped = 1'b0;
    r.lim = 1'b0;
    if (m == lei_pkg::MODE_LOAD) begin
      px = ix;
      py = iy;
      pz = iz;
      pt = it;
      nsteps = '0;
    end else if (nsteps >= step_cap) begin
      // past the limit: state frozen
      r.lim = 1'b1;
    end else begin
      x = px;
      y = py;
      z = pz;
      dx = fx_product(sigma, y - x, clipped);
      dy = fx_product(x, longint'(rho) - z, clipped) - y;
      dz = fx_product(x, y, clipped) - fx_product(beta, z, clipped);
      px = lei_pkg::VALUE_WIDTH'(clip_to(x + fx_product(h, dx, clipped), VAL_LO, VAL_HI,
                                         clipped));
      py = lei_pkg::VALUE_WIDTH'(clip_to(y + fx_product(h, dy, clipped), VAL_LO, VAL_HI,
                                         clipped));
      pz = lei_pkg::VALUE_WIDTH'(clip_to(z + fx_product(h, dz, clipped), VAL_LO, VAL_HI,
                                         clipped));
      pt = lei_pkg::TIME_WIDTH'(clip_to(longint'(pt) + longint'(h), TIME_LO, TIME_HI,
                                        clipped));
      nsteps = nsteps + 1'b1;
    end
    r.x = px;
    r.y = py;
    r.z = pz;
    r.t = pt;
    r.n = nsteps;
    r.sat = clipped;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_val,
                             input logic signed [63:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  // Watch all three channels on each edge
  always @(posedge clk) begin
    if (rst) begin
      sigma = lei_pkg::SIGMA_RST;
      rho = lei_pkg::RHO_RST;
      beta = lei_pkg::BETA_RST;
      h = lei_pkg::STEP_RST;
      step_cap = lei_pkg::LIMIT_RST;
      px = '0;
      py = '0;
      pz = '0;
      pt = '0;
      nsteps = '0;
      expected_points.delete();
    end else begin
      // result transfer: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result, x %0d y %0d z %0d time %0d", $time,
                   cur_x, cur_y, cur_z, cur_time);
          errors++;
        end else begin
          want = expected_points.pop_front();
          check_field("cur_x", want.x, cur_x);
          check_field("cur_y", want.y, cur_y);
          check_field("cur_z", want.z, cur_z);
          check_field("cur_time", want.t, cur_time);
          check_field("steps_done", want.n, steps_done);
          check_field("limit_reached", want.lim, limit_reached);
          check_field("saturated", want.sat, saturated);
        end
      end
      // register write; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lei_pkg::REG_SIGMA: sigma = cfg_data;
          lei_pkg::REG_RHO:   rho = cfg_data;
          lei_pkg::REG_BETA:  beta = cfg_data;
          lei_pkg::REG_STEP:  h = cfg_data;
          lei_pkg::REG_LIMIT: step_cap = cfg_data[lei_pkg::LIMIT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_points.push_back(apply_item(mode, init_x, init_y, init_z, start_time));
    end
    pending <= expected_points.size();
  end

endmodule

>>> test/lorenz_euler_integrator_top_tb.sv
// Testbench top for the Lorenz Euler integrator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module lorenz_euler_integrator_top_tb;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 24;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 133;
  localparam int IDX_TOP     = (1 << lei_pkg::CFG_IDX_W) - 1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [lei_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lei_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, mode;
  logic signed [lei_pkg::VALUE_WIDTH-1:0] init_x, init_y, init_z;
  logic signed [lei_pkg::TIME_WIDTH-1:0] start_time;
  logic out_valid, out_ready;
  logic signed [lei_pkg::VALUE_WIDTH-1:0] cur_x, cur_y, cur_z;
  logic signed [lei_pkg::TIME_WIDTH-1:0] cur_time;
  logic [lei_pkg::LIMIT_WIDTH-1:0] steps_done;
  logic limit_reached, saturated;
  int errors, pending;
  bit hold_req, hold_on;

  always #10 clk = ~clk;

  lorenz_euler_integrator_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .init_x(init_x), .init_y(init_y), .init_z(init_z), .start_time(start_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z), .cur_time(cur_time),
    .steps_done(steps_done), .limit_reached(limit_reached), .saturated(saturated)
  );

  lorenz_step_checker step_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .init_x(init_x), .init_y(init_y), .init_z(init_z), .start_time(start_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z), .cur_time(cur_time),
    .steps_done(steps_done), .limit_reached(limit_reached), .saturated(saturated),
    .errors(errors), .pending(pending)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic logic [lei_pkg::VALUE_WIDTH-1:0] extreme_val();
    case ($urandom_range(0, 5))
      0: return lei_pkg::VAL_MAX;
      1: return lei_pkg::VAL_MIN;
      2: return '0;
      3: return '1;
      4: return 1 << lei_pkg::FRAC_BITS;
      default: return $urandom;
    endcase
  endfunction

  // Point coordinate: mostly on the attractor's scale, sometimes anywhere
  function automatic logic [lei_pkg::VALUE_WIDTH-1:0] coord();
    case ($urandom_range(0, 3))
      0, 1: return 32'($urandom_range(0, 62914560)) - 32'd31457280;
      2: return $urandom;
      default: return extreme_val();
    endcase
  endfunction

  function automatic logic [lei_pkg::TIME_WIDTH-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(0, 1 << 24));
      2: return lei_pkg::TIME_MAX - 48'($urandom_range(0, 100000));
      default: return lei_pkg::TIME_MIN + 48'($urandom_range(0, 100000));
    endcase
  endfunction

  // Present one item and hold it until the transfer; valid is left high
  task automatic offer(input logic m, input logic [lei_pkg::VALUE_WIDTH-1:0] px,
                       input logic [lei_pkg::VALUE_WIDTH-1:0] py,
                       input logic [lei_pkg::VALUE_WIDTH-1:0] pz,
                       input logic [lei_pkg::TIME_WIDTH-1:0] pt);
    in_valid <= 1'b1;
    mode <= m;
    init_x <= px;
    init_y <= py;
    init_z <= pz;
    start_time <= pt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 9) == 0)
      offer(lei_pkg::MODE_LOAD, coord(), coord(), coord(), rand_time());
    else
      offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
  endtask

  task automatic pause();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [lei_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lei_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All five registers, then a write to an unused index
  task automatic configure(input logic [lei_pkg::CFG_DATA_W-1:0] s,
                           input logic [lei_pkg::CFG_DATA_W-1:0] r,
                           input logic [lei_pkg::CFG_DATA_W-1:0] b,
                           input logic [lei_pkg::CFG_DATA_W-1:0] hs,
                           input logic [lei_pkg::CFG_DATA_W-1:0] lim);
    write_reg(lei_pkg::REG_SIGMA, s);
    write_reg(lei_pkg::REG_RHO, r);
    write_reg(lei_pkg::REG_BETA, b);
    write_reg(lei_pkg::REG_STEP, hs);
    write_reg(lei_pkg::REG_LIMIT, lim);
    write_reg(lei_pkg::CFG_IDX_W'($urandom_range(int'(lei_pkg::REG_LIMIT) + 1, IDX_TOP)),
              $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random ready bursts, plus one long hold-off on request
  initial begin : receiver
    int burst, gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_on = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
        hold_req = 1'b0;
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (burst) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Give up when no channel has had a transfer for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("lorenz_euler_integrator_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int ph, k;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    mode <= lei_pkg::MODE_LOAD;
    init_x <= '0;
    init_y <= '0;
    init_z <= '0;
    start_time <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: step from the origin, then a small point
    offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
    offer(lei_pkg::MODE_LOAD, 1 << lei_pkg::FRAC_BITS, 1 << lei_pkg::FRAC_BITS,
          1 << lei_pkg::FRAC_BITS, '0);
    repeat (3) offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
    // Extreme points: products, coordinates and time all clip
    offer(lei_pkg::MODE_LOAD, lei_pkg::VAL_MAX, lei_pkg::VAL_MIN, lei_pkg::VAL_MAX,
          lei_pkg::TIME_MAX);
    offer(lei_pkg::MODE_STEP, '0, '0, '0, '0);
    offer(lei_pkg::MODE_LOAD, lei_pkg::VAL_MIN, lei_pkg::VAL_MIN, lei_pkg::VAL_MIN,
          lei_pkg::TIME_MIN);
    offer(lei_pkg::MODE_STEP, '1, '1, '1, '1);
    // All ones: negative products round toward minus infinity
    offer(lei_pkg::MODE_LOAD, '1, '1, '1, '1);
    offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
    drain();

    // Zero limit: every step is ignored
    configure(lei_pkg::SIGMA_RST, lei_pkg::RHO_RST, lei_pkg::BETA_RST, lei_pkg::STEP_RST,
              '0);
    offer(lei_pkg::MODE_LOAD, 2 << lei_pkg::FRAC_BITS, 3 << lei_pkg::FRAC_BITS,
          4 << lei_pkg::FRAC_BITS, 48'd12345);
    repeat (2) offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
    drain();

    // Limit of two with junk in the upper data bits; negative step drives time under
    configure(lei_pkg::SIGMA_RST, lei_pkg::RHO_RST, lei_pkg::BETA_RST, -lei_pkg::STEP_RST,
              32'hABCD_0002);
    offer(lei_pkg::MODE_LOAD, 1 << lei_pkg::FRAC_BITS, 2 << lei_pkg::FRAC_BITS,
          3 << lei_pkg::FRAC_BITS, lei_pkg::TIME_MIN + 48'd5);
    repeat (3) offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
    drain();

    // Extreme coefficients, full limit
    configure(lei_pkg::VAL_MIN, lei_pkg::VAL_MAX, lei_pkg::VAL_MIN, lei_pkg::VAL_MAX,
              32'h0000_FFFF);
    offer(lei_pkg::MODE_LOAD, 5 << lei_pkg::FRAC_BITS, -(7 << lei_pkg::FRAC_BITS),
          9 << lei_pkg::FRAC_BITS, '0);
    repeat (2) offer(lei_pkg::MODE_STEP, $urandom, $urandom, $urandom, rand_time());
    drain();

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: configure(lei_pkg::SIGMA_RST, lei_pkg::RHO_RST, lei_pkg::BETA_RST,
                     lei_pkg::STEP_RST, $urandom_range(0, 40));
        1: configure($urandom_range(5 << 20, 15 << 20), $urandom_range(10 << 20, 40 << 20),
                     $urandom_range(1 << 20, 4 << 20), $urandom_range(1, 20000),
                     $urandom_range(0, 1) ? 32'h0000_FFFF : 32'd1000);
        2: configure($urandom, $urandom, $urandom, $urandom, $urandom);
        default: configure(extreme_val(), extreme_val(), extreme_val(), extreme_val(),
                           extreme_val());
      endcase
      offer(lei_pkg::MODE_LOAD, coord(), coord(), coord(), rand_time());
      pause();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 40) begin
          // back-pressure: results held while items keep coming
          drain();
          hold_req = 1'b1;
          wait (hold_on);
          repeat (20) random_item();
        end
        random_item();
        pause();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("lorenz_euler_integrator_top_tb: clean");
    else
      $display("lorenz_euler_integrator_top_tb: errors");
    $finish;
  end

endmodule
